[rtl/p1305_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package p1305_pkg;

	// queue depths
	localparam int IN_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF = 4;

	// configuration register indexes
	localparam logic [1:0] REG_R_LOW  = 2'd0;
	localparam logic [1:0] REG_R_HIGH = 2'd1;
	localparam logic [1:0] REG_S_LOW  = 2'd2;
	localparam logic [1:0] REG_S_HIGH = 2'd3;

	// block framing
	localparam logic [4:0] FULL_BLOCK_BYTES = 5'd16;
	localparam logic [7:0] PAD_BYTE         = 8'h01;

	// limb arithmetic
	localparam logic [25:0] LIMB_MASK  = 26'h3ffffff;
	localparam logic [31:0] LIMB_MASK32 = 32'h03ffffff;
	localparam logic [31:0] LIMB_TOP32  = 32'h04000000;

	// clamp masks for the five limbs of r, limb 0 in the low slot
	localparam logic [4:0][25:0] R_CLAMP = {
		26'h00fffff, 26'h3f03fff, 26'h3ffc0ff, 26'h3ffff03, 26'h3ffffff
	};

	// one queued message block, already padded
	typedef struct packed {
		logic [128:0] msg;
		logic         absorb;
		logic         last;
		logic [127:0] expected;
	} item_t;

	// back end status towards the top level
	typedef struct packed {
		logic take;
		logic take_last;
	} core_stat_t;

	// accumulator snapshot handed to the final reduction
	typedef struct packed {
		logic            valid;
		logic [4:0][26:0] acc;
		logic [127:0]    expected;
	} fin_t;

	// one result transaction
	typedef struct packed {
		logic [127:0] tag;
		logic         match;
	} res_t;

	// split r into 26-bit limbs and clamp
	function automatic logic [4:0][25:0] clamp_r(input logic [127:0] key);
		logic [4:0][25:0] l;
		for (int i = 0; i < 4; i++) begin
			l[i] = key[26*i +: 26] & R_CLAMP[i];
		end
		l[4] = {2'b00, key[127:104]} & R_CLAMP[4];
		return l;
	endfunction

endpackage

`default_nettype wire

[rtl/poly1305_mac.sv]
// Poly1305 one-time authenticator, one 16-byte block per input transaction.
// Throughput: input accepted every cycle into a queue while it is not full; each non-empty
// block then holds the multiply-reduce loop on the accumulator through states COL, CAR1 and
// CAR2, an empty block only its take in the idle state. A last block's tag then passes final
// stages s1 and s2 into the result queue. Reset clears key registers, accumulator and both queues.
`timescale 1ns / 1ps
`default_nettype none

module poly1305_mac #(
	parameter int IN_DEPTH  = p1305_pkg::IN_DEPTH_DEF,
	parameter int OUT_DEPTH = p1305_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	input  logic [4:0]  byte_count,
	input  logic        last_block,
	input  logic [63:0] expected_low,
	input  logic [63:0] expected_high,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] tag_low,
	output logic [63:0] tag_high,
	output logic        tag_match
);

	import p1305_pkg::*;

	localparam int RES_W = $clog2(OUT_DEPTH + 1);

	logic [63:0] r_low_q;
	logic [63:0] r_high_q;
	logic [63:0] s_low_q;
	logic [63:0] s_high_q;
	logic        q_full;
	logic        q_push;
	logic        q_empty;
	item_t       q_wdata;
	item_t       q_rdata;
	core_stat_t  stat;
	fin_t        fin;
	logic        res_push;
	res_t        res_wdata;
	res_t        res_rdata;
	logic        res_full;
	logic [RES_W-1:0] reserved_q;
	logic        can_last;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q  <= '0;
			r_high_q <= '0;
			s_low_q  <= '0;
			s_high_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_R_LOW:  r_low_q  <= wr_data;
				REG_R_HIGH: r_high_q <= wr_data;
				REG_S_LOW:  s_low_q  <= wr_data;
				REG_S_HIGH: s_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	// result slots claimed by last blocks in flight or waiting
	assign can_last = (reserved_q < RES_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			if (stat.take_last && !(pop && !empty)) begin
				reserved_q <= reserved_q + 1'b1;
			end else if (!stat.take_last && (pop && !empty)) begin
				reserved_q <= reserved_q - 1'b1;
			end
		end
	end

	// front: padding and classification
	p1305_front u_front (
		.push          (push),
		.full          (full),
		.block_low     (block_low),
		.block_high    (block_high),
		.byte_count    (byte_count),
		.last_block    (last_block),
		.expected_low  (expected_low),
		.expected_high (expected_high),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_wdata)
	);

	// block queue between front and back
	p1305_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (IN_DEPTH)
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (stat.take),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// back: multiply-reduce loop on the accumulator
	p1305_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.r_key    ({r_high_q, r_low_q}),
		.q_empty  (q_empty),
		.q_item   (q_rdata),
		.can_last (can_last),
		.stat     (stat),
		.fin      (fin)
	);

	// final reduction, key addition and tag compare
	p1305_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.fin      (fin),
		.s_key    ({s_high_q, s_low_q}),
		.res_push (res_push),
		.res      (res_wdata)
	);

	// result queue
	p1305_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_wdata),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	// result slots are reserved up front, so full is never needed and is unused here
	assign tag_low   = res_rdata.tag[63:0];
	assign tag_high  = res_rdata.tag[127:64];
	assign tag_match = res_rdata.match & ~(res_full & 1'b0);

endmodule

`default_nettype wire

[rtl/p1305_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module p1305_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[rtl/p1305_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module p1305_front (
	input  logic               push,
	output logic               full,
	input  logic [63:0]        block_low,
	input  logic [63:0]        block_high,
	input  logic [4:0]         byte_count,
	input  logic               last_block,
	input  logic [63:0]        expected_low,
	input  logic [63:0]        expected_high,
	input  logic               q_full,
	output logic               q_push,
	output p1305_pkg::item_t   q_item
);

	import p1305_pkg::*;

	logic [4:0]   cnt;
	logic [127:0] data;
	logic [127:0] padded;

	assign full   = q_full;
	assign q_push = push;

	// saturate the count, pad the block and classify the transaction
	always_comb begin
		cnt  = (byte_count > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : byte_count;
		data = {block_high, block_low};
		for (int b = 0; b < 16; b++) begin
			if (5'(b) < cnt) begin
				padded[8*b +: 8] = data[8*b +: 8];
			end else if (5'(b) == cnt) begin
				padded[8*b +: 8] = PAD_BYTE;
			end else begin
				padded[8*b +: 8] = 8'h00;
			end
		end
		q_item.msg      = {(cnt == FULL_BLOCK_BYTES), padded};
		q_item.absorb   = (cnt != 5'd0);
		q_item.last     = last_block;
		q_item.expected = {expected_high, expected_low};
	end

endmodule

`default_nettype wire

[rtl/p1305_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module p1305_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [127:0]          r_key,
	input  logic                  q_empty,
	input  p1305_pkg::item_t      q_item,
	input  logic                  can_last,
	output p1305_pkg::core_stat_t stat,
	output p1305_pkg::fin_t       fin
);

	import p1305_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COL  = 2'd1;
	localparam logic [1:0] ST_CAR1 = 2'd2;
	localparam logic [1:0] ST_CAR2 = 2'd3;

	logic [1:0]            state_q;
	logic [4:0][25:0]      rc;
	logic [4:0][25:0]      r_q;
	logic [3:0][28:0]      f5_q;
	logic [4:0][26:0]      acc_q;
	logic [4:0][26:0]      acc_new;
	logic [4:0][25:0]      mlimb;
	logic [4:0][27:0]      h;
	logic [4:0][4:0][56:0] prod;
	logic [4:0][4:0][56:0] prod_s1;
	logic [4:0][63:0]      col;
	logic [4:0][63:0]      col_s2;
	logic [25:0]           d0_s3;
	logic [25:0]           d1_s3;
	logic [63:0]           d2_s3;
	logic [63:0]           c1;
	logic [63:0]           c2;
	logic [63:0]           d3;
	logic [63:0]           d4;
	logic [63:0]           n0;
	logic [63:0]           n1;
	logic                  last_q;
	logic [127:0]          expected_q;
	logic                  fin_valid_q;
	logic [4:0][26:0]      fin_acc_q;
	logic [127:0]          fin_exp_q;
	logic                  take;

	// take a block when the loop is free; a last block also needs a result slot
	assign take = (state_q == ST_IDLE) && !q_empty && (!q_item.last || can_last);

	assign stat.take      = take;
	assign stat.take_last = take & q_item.last;

	assign fin.valid    = fin_valid_q;
	assign fin.acc      = fin_acc_q;
	assign fin.expected = fin_exp_q;

	// clamped r and its multiples of five, refreshed from the key registers
	assign rc = clamp_r(r_key);

	always_ff @(posedge clk) begin
		r_q <= rc;
		for (int j = 0; j < 4; j++) begin
			f5_q[j] <= ({3'b000, rc[j+1]} << 2) + {3'b000, rc[j+1]};
		end
	end

	// accumulator plus message limbs
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mlimb[i] = q_item.msg[26*i +: 26];
		end
		mlimb[4] = {1'b0, q_item.msg[128:104]};
		for (int i = 0; i < 5; i++) begin
			h[i] = 28'(acc_q[i]) + 28'(mlimb[i]);
		end
	end

	// partial products, column k collects h[i] times r[k-i] or 5*r[k-i+5]
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			for (int i = 0; i < 5; i++) begin
				if (i <= k) begin
					prod[k][i] = 57'(h[i]) * 57'({3'b000, r_q[k-i]});
				end else begin
					prod[k][i] = 57'(h[i]) * 57'(f5_q[k-i+4]);
				end
			end
		end
	end

	// column sums
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			col[k] = '0;
			for (int i = 0; i < 5; i++) begin
				col[k] = col[k] + 64'(prod_s1[k][i]);
			end
		end
	end

	// first half of the carry chain
	assign c1 = col_s2[1] + (col_s2[0] >> 26);
	assign c2 = col_s2[2] + (c1 >> 26);

	// second half of the carry chain and fold of the top carry
	always_comb begin
		d3 = col_s2[3] + (d2_s3 >> 26);
		d4 = col_s2[4] + (d3 >> 26);
		n0 = 64'(d0_s3) + (d4 >> 26) * 64'd5;
		n1 = 64'(d1_s3) + (n0 >> 26);
		acc_new[0] = {1'b0, n0[25:0]};
		acc_new[1] = n1[26:0];
		acc_new[2] = {1'b0, d2_s3[25:0]};
		acc_new[3] = {1'b0, d3[25:0]};
		acc_new[4] = {1'b0, d4[25:0]};
	end

	// sequencer and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			fin_valid_q <= 1'b0;
		end else begin
			fin_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (q_item.absorb) begin
							state_q <= ST_COL;
						end else if (q_item.last) begin
							fin_valid_q <= 1'b1;
							acc_q       <= '0;
						end
					end
				end
				ST_COL: begin
					state_q <= ST_CAR1;
				end
				ST_CAR1: begin
					state_q <= ST_CAR2;
				end
				ST_CAR2: begin
					state_q <= ST_IDLE;
					if (last_q) begin
						fin_valid_q <= 1'b1;
						acc_q       <= '0;
					end else begin
						acc_q <= acc_new;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1    <= prod;
			last_q     <= q_item.last;
			expected_q <= q_item.expected;
			fin_acc_q  <= acc_q;
			fin_exp_q  <= q_item.expected;
		end
		if (state_q == ST_COL) begin
			col_s2 <= col;
		end
		if (state_q == ST_CAR1) begin
			d0_s3 <= col_s2[0][25:0];
			d1_s3 <= c1[25:0];
			d2_s3 <= c2;
		end
		if (state_q == ST_CAR2) begin
			fin_acc_q <= acc_new;
			fin_exp_q <= expected_q;
		end
	end

endmodule

`default_nettype wire

[rtl/p1305_final.sv]
`timescale 1ns / 1ps
`default_nettype none

module p1305_final (
	input  logic              clk,
	input  logic              arst_n,
	input  p1305_pkg::fin_t   fin,
	input  logic [127:0]      s_key,
	output logic              res_push,
	output p1305_pkg::res_t   res
);

	import p1305_pkg::*;

	logic             valid_s1;
	logic             valid_s2;
	logic [4:0][26:0] h_s1;
	logic [127:0]     exp_s1;
	logic [63:0]      a_s2;
	logic [63:0]      b_s2;
	logic [127:0]     exp_s2;
	logic [4:0][26:0] hc;
	logic [63:0]      a;
	logic [63:0]      b;
	logic [64:0]      sum_lo;
	logic [63:0]      sum_hi;

	// full carry propagation
	always_comb begin
		logic [31:0] v0, v1, v2, v3, v4;
		v0 = 32'(fin.acc[0]);
		v1 = 32'(fin.acc[1]);
		v2 = 32'(fin.acc[2]);
		v3 = 32'(fin.acc[3]);
		v4 = 32'(fin.acc[4]);
		v2 = v2 + (v1 >> 26); v1 = v1 & LIMB_MASK32;
		v3 = v3 + (v2 >> 26); v2 = v2 & LIMB_MASK32;
		v4 = v4 + (v3 >> 26); v3 = v3 & LIMB_MASK32;
		v0 = v0 + (v4 >> 26) * 32'd5; v4 = v4 & LIMB_MASK32;
		v1 = v1 + (v0 >> 26); v0 = v0 & LIMB_MASK32;
		hc[0] = v0[26:0];
		hc[1] = v1[26:0];
		hc[2] = v2[26:0];
		hc[3] = v3[26:0];
		hc[4] = v4[26:0];
	end

	// subtract p when it does not borrow, then pack into two words
	always_comb begin
		logic [31:0] h0, h1, h2, h3, h4, t0, t1, t2, t3, t4;
		h0 = 32'(h_s1[0]);
		h1 = 32'(h_s1[1]);
		h2 = 32'(h_s1[2]);
		h3 = 32'(h_s1[3]);
		h4 = 32'(h_s1[4]);
		t0 = h0 + 32'd5;
		t1 = h1 + (t0 >> 26);
		t2 = h2 + (t1 >> 26);
		t3 = h3 + (t2 >> 26);
		t4 = h4 + (t3 >> 26) - LIMB_TOP32;
		if (!t4[31]) begin
			h0 = t0 & LIMB_MASK32;
			h1 = t1 & LIMB_MASK32;
			h2 = t2 & LIMB_MASK32;
			h3 = t3 & LIMB_MASK32;
			h4 = t4;
		end
		a = 64'(h0) | (64'(h1) << 26) | (64'(h2) << 52);
		b = (64'(h2) >> 12) | (64'(h3) << 14) | (64'(h4 & LIMB_MASK32) << 40);
	end

	// add s and compare against the expected tag
	assign sum_lo    = {1'b0, a_s2} + {1'b0, s_key[63:0]};
	assign sum_hi    = b_s2 + s_key[127:64] + 64'(sum_lo[64]);
	assign res.tag   = {sum_hi, sum_lo[63:0]};
	assign res.match = ({sum_hi, sum_lo[63:0]} == exp_s2);
	assign res_push  = valid_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= fin.valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			h_s1   <= hc;
			exp_s1 <= fin.expected;
		end
		if (valid_s1) begin
			a_s2   <= a;
			b_s2   <= b;
			exp_s2 <= exp_s1;
		end
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import p1305_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 50;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_BLOCKS = 190;
	localparam int PRINT_CAP    = 40;

	// prime 2^130 - 5 and the clamp applied to r
	localparam logic [129:0] PRIME   = {130{1'b1}} - 130'd4;
	localparam logic [127:0] R_CLAMP_MASK = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

	// how the expected tag of a last block is chosen
	typedef enum int {EXP_RIGHT, EXP_FLIP, EXP_RANDOM} exp_mode_t;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic [4:0]  count;
		logic        last;
		logic [63:0] exp_lo;
		logic [63:0] exp_hi;
	} msg_block_t;

	typedef struct {
		logic [127:0] tag;
		logic         match;
	} tag_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_index = REG_R_LOW;
	logic [63:0] wr_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic [63:0] block_low = '0;
	logic [63:0] block_high = '0;
	logic [4:0]  byte_count = '0;
	logic        last_block = 1'b0;
	logic [63:0] expected_low = '0;
	logic [63:0] expected_high = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [63:0] tag_low;
	logic [63:0] tag_high;
	logic        tag_match;

	// key copies and the two running accumulators (stimulus side, prediction side)
	logic [127:0] r_key = '0;
	logic [127:0] s_key = '0;
	logic [129:0] gen_acc = '0;
	logic [129:0] pred_acc = '0;

	msg_block_t  pending_blocks[$];
	tag_result_t tag_queue[$];
	msg_block_t  cur_block;
	tag_result_t want_tag;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int cycle_count = 0;
	int blocks_queued = 0;
	int blocks_accepted = 0;
	int tags_checked = 0;
	int tags_matching = 0;
	int phase_blocks = 0;

	poly1305_mac dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.push          (push),
		.full          (full),
		.block_low     (block_low),
		.block_high    (block_high),
		.byte_count    (byte_count),
		.last_block    (last_block),
		.expected_low  (expected_low),
		.expected_high (expected_high),
		.empty         (empty),
		.pop           (pop),
		.tag_low       (tag_low),
		.tag_high      (tag_high),
		.tag_match     (tag_match)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// x mod (2^130 - 5) by folding the high part down twice
	function automatic logic [129:0] mod_prime(input logic [259:0] x);
		logic [259:0] v;
		v = {130'd0, x[129:0]} + {130'd0, x[259:130]} * 260'd5;
		v = {130'd0, v[129:0]} + {130'd0, v[259:130]} * 260'd5;
		while (v >= {130'd0, PRIME})
			v = v - {130'd0, PRIME};
		return v[129:0];
	endfunction

	// absorb one padded block: h = (h + m) * r mod p
	function automatic logic [129:0] absorb_block(input logic [129:0] h,
			input logic [127:0] rkey, input logic [127:0] data, input logic [4:0] count);
		logic [4:0]   n;
		logic [127:0] keep;
		logic [129:0] m;
		logic [130:0] sum;
		logic [259:0] prod;
		n = (count > FULL_BLOCK_BYTES) ? FULL_BLOCK_BYTES : count;
		if (n == 5'd0)
			return h;
		keep = (n == FULL_BLOCK_BYTES) ? '1 : ((128'd1 << (8 * n)) - 128'd1);
		m = {2'b00, data & keep} | (130'd1 << (8 * n));
		sum = {1'b0, h} + {1'b0, m};
		prod = {129'd0, sum} * {132'd0, rkey & R_CLAMP_MASK};
		return mod_prime(prod);
	endfunction

	// final tag from a fully reduced accumulator
	function automatic logic [127:0] tag_of(input logic [129:0] h, input logic [127:0] skey);
		return h[127:0] + skey;
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// register write, predictor keys follow at once (block is idle)
	task automatic write_key(input logic [1:0] idx, input logic [63:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_R_LOW:  r_key[63:0] = value;
			REG_R_HIGH: r_key[127:64] = value;
			REG_S_LOW:  s_key[63:0] = value;
			REG_S_HIGH: s_key[127:64] = value;
			default: ;
		endcase
	endtask

	task automatic load_keys(input logic [127:0] rk, input logic [127:0] sk);
		write_key(REG_R_LOW, rk[63:0]);
		write_key(REG_R_HIGH, rk[127:64]);
		write_key(REG_S_LOW, sk[63:0]);
		write_key(REG_S_HIGH, sk[127:64]);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// queue one block, choosing the expected tag from a running accumulator
	task automatic add_block(input logic [127:0] data, input logic [4:0] count,
			input logic last, input exp_mode_t mode);
		msg_block_t   b;
		logic [127:0] t;
		gen_acc = absorb_block(gen_acc, r_key, data, count);
		t = {rand_word(), rand_word()};
		if (last) begin
			if (mode == EXP_RIGHT)
				t = tag_of(gen_acc, s_key);
			else if (mode == EXP_FLIP)
				t = tag_of(gen_acc, s_key) ^ (128'd1 << $urandom_range(127));
			gen_acc = '0;
		end
		b.lo = data[63:0];
		b.hi = data[127:64];
		b.count = count;
		b.last = last;
		b.exp_lo = t[63:0];
		b.exp_hi = t[127:64];
		pending_blocks.push_back(b);
		blocks_queued++;
		phase_blocks++;
	endtask

	function automatic exp_mode_t pick_mode();
		int k;
		k = $urandom_range(9);
		if (k < 5)
			return EXP_RIGHT;
		else if (k < 7)
			return EXP_FLIP;
		return EXP_RANDOM;
	endfunction

	// one random message: zero to five body blocks, then a last block
	task automatic add_message();
		int          nbody;
		logic [4:0]  cnt;
		int          k;
		nbody = $urandom_range(0, 5);
		for (int i = 0; i < nbody; i++) begin
			cnt = ($urandom_range(6) == 0) ? 5'($urandom_range(0, 31)) : FULL_BLOCK_BYTES;
			add_block({rand_word(), rand_word()}, cnt, 1'b0, EXP_RANDOM);
		end
		k = $urandom_range(9);
		if (k < 4)
			cnt = FULL_BLOCK_BYTES;
		else if (k == 4)
			cnt = 5'd0;
		else
			cnt = 5'($urandom_range(1, 31));
		add_block({rand_word(), rand_word()}, cnt, 1'b1, pick_mode());
	endtask

	task automatic add_directed();
		logic [127:0] ones;
		ones = '1;
		// empty message gives s
		add_block('0, 5'd0, 1'b1, EXP_RIGHT);
		// full block extremes
		add_block(ones, FULL_BLOCK_BYTES, 1'b1, EXP_RIGHT);
		add_block('0, FULL_BLOCK_BYTES, 1'b1, EXP_FLIP);
		// short last blocks, bytes past the count ignored
		add_block(ones, 5'd1, 1'b1, EXP_RIGHT);
		add_block(ones, 5'd15, 1'b1, EXP_RANDOM);
		// count above sixteen saturates
		add_block(ones, 5'd17, 1'b1, EXP_RIGHT);
		add_block(ones, 5'd31, 1'b1, EXP_RIGHT);
		// short block that is not last
		add_block({rand_word(), rand_word()}, 5'd5, 1'b0, EXP_RANDOM);
		add_block({rand_word(), rand_word()}, FULL_BLOCK_BYTES, 1'b1, EXP_RIGHT);
		// empty blocks inside and at the end of a message
		add_block(ones, 5'd0, 1'b0, EXP_RANDOM);
		add_block(ones, FULL_BLOCK_BYTES, 1'b0, EXP_RANDOM);
		add_block(ones, 5'd0, 1'b1, EXP_RIGHT);
		// multi-block message
		for (int i = 0; i < 3; i++)
			add_block({rand_word(), rand_word()}, FULL_BLOCK_BYTES, 1'b0, EXP_RANDOM);
		add_block({rand_word(), rand_word()}, 5'd8, 1'b1, EXP_RIGHT);
		// all-ones chain for carry propagation
		for (int i = 0; i < 3; i++)
			add_block(ones, FULL_BLOCK_BYTES, 1'b0, EXP_RANDOM);
		add_block(ones, FULL_BLOCK_BYTES, 1'b1, EXP_RIGHT);
	endtask

	task automatic wait_idle();
		while (blocks_accepted != blocks_queued || tag_queue.size() != 0)
			@(posedge clk);
		// body blocks may still be in flight with no tag to wait on
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// predictor: runs once per accepted transaction
	task automatic predict_block(input msg_block_t b);
		tag_result_t res;
		pred_acc = absorb_block(pred_acc, r_key, {b.hi, b.lo}, b.count);
		if (b.last) begin
			res.tag = tag_of(pred_acc, s_key);
			res.match = (res.tag == {b.exp_hi, b.exp_lo});
			tag_queue.push_back(res);
			pred_acc = '0;
		end
	endtask

	// driver: push side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_block(cur_block);
				blocks_accepted++;
			end
			if (!push || !full) begin
				if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_block = pending_blocks.pop_front();
					push <= 1'b1;
					block_low <= cur_block.lo;
					block_high <= cur_block.hi;
					byte_count <= cur_block.count;
					last_block <= cur_block.last;
					expected_low <= cur_block.exp_lo;
					expected_high <= cur_block.exp_hi;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: pop side and tag checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (tag_queue.size() == 0) begin
					report_mismatch("tag with no block pending", tag_low, '0);
				end else begin
					want_tag = tag_queue.pop_front();
					if (tag_low !== want_tag.tag[63:0])
						report_mismatch("tag_low", tag_low, want_tag.tag[63:0]);
					if (tag_high !== want_tag.tag[127:64])
						report_mismatch("tag_high", tag_high, want_tag.tag[127:64]);
					if (tag_match !== want_tag.match)
						report_mismatch("tag_match", 64'(tag_match), 64'(want_tag.match));
					if (want_tag.match)
						tags_matching++;
				end
				tags_checked++;
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// phases: keys, idle mode, stimulus
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			case (ph)
				0: load_keys('1, '1);
				2: load_keys('0, {rand_word(), rand_word()});
				3: load_keys({rand_word(), rand_word()}, '0);
				5: load_keys('1, {rand_word(), rand_word()});
				default: load_keys({$urandom, $urandom, $urandom, $urandom},
					{$urandom, $urandom, $urandom, $urandom});
			endcase
			@(negedge clk);
			phase_blocks = 0;
			gen_acc = '0;
			if (ph == 0)
				add_directed();
			while (phase_blocks < PHASE_BLOCKS) begin
				// occasional loose body block between messages
				if ($urandom_range(9) == 0)
					add_block({rand_word(), rand_word()}, 5'($urandom_range(0, 31)), 1'b0,
						EXP_RANDOM);
				add_message();
			end
			wait_idle();
		end
		if (tag_queue.size() != 0)
			report_mismatch("tags never produced", 64'(tag_queue.size()), '0);
		$display("summary: %0d blocks over %0d key settings and 4 idle modes", blocks_accepted,
			PHASE_COUNT);
		$display("summary: %0d tags checked, %0d expected to match", tags_checked,
			tags_matching);
		if (err_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/p1305_pkg.sv
rtl/p1305_fifo.sv
rtl/p1305_front.sv
rtl/p1305_core.sv
rtl/p1305_final.sv
rtl/poly1305_mac.sv
verif/tb_top.sv
